// ===== design/rmfw_pkg.sv =====
// Shared types and constants for the recursive mutex with FIFO wait queue.
`default_nettype none
package rmfw_pkg;

  localparam int TID_W    = 4;
  localparam int STATUS_W = 4;
  localparam int HOLD_W   = 8;
  localparam int WAIT_W   = 5;

  localparam int DEF_NUM_THREADS = 16;
  localparam int DEF_COUNT_BITS  = 8;

  localparam logic       MODE_ACQUIRE = 1'b0;
  localparam logic       MODE_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GRANT      = 4'd0;
  localparam logic [STATUS_W-1:0] ST_RECURSED   = 4'd1;
  localparam logic [STATUS_W-1:0] ST_BLOCKED    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_LOWERED    = 4'd3;
  localparam logic [STATUS_W-1:0] ST_FREED      = 4'd4;
  localparam logic [STATUS_W-1:0] ST_HANDOFF    = 4'd5;
  localparam logic [STATUS_W-1:0] ST_NOT_HOLDER = 4'd6;
  localparam logic [STATUS_W-1:0] ST_DUP_WAIT   = 4'd7;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 4'd8;

  typedef struct packed {
    logic             mode;
    logic [TID_W-1:0] thread_id;
  } req_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                woken_valid;
    logic [TID_W-1:0]    woken_thread;
    logic                lock_held;
    logic [TID_W-1:0]    holder_thread;
    logic [HOLD_W-1:0]   hold_count;
    logic [WAIT_W-1:0]   waiting_count;
  } rsp_beat_t;

endpackage
`default_nettype wire

// ===== design/recursive_mutex_fifo_waiters_top.sv =====
// Recursive mutex with strict arrival-order hand-off through a FIFO wait queue.
//
// Request channel (req_valid/req_ready/req) carries one beat per lock request:
// acquire or release on behalf of a thread. Response channel
// (rsp_valid/rsp_ready/rsp) returns exactly one beat per request with the
// status and the lock and queue state after it.
// Each request is taken in the idle state while the wait-queue memory is read
// at the head pointer; the execute state then reads the registered queue entry,
// updates the lock state, writes the queue at the tail and loads the response
// register. A new request is taken only after the previous one has left the
// execute state; the queue memory read at the head pointer is registered.
// A response beat can wait in its register while the next request is taken;
// if it is still not taken when the next result is ready, the block holds in
// its execute state and req_ready stays low until rsp_ready frees the register.
// Reset (rst, synchronous) frees the lock, empties the queue and clears the
// waiting map; the queue memory itself is not cleared and needs no pass.
`default_nettype none
module recursive_mutex_fifo_waiters_top #(
  parameter int NUM_THREADS = rmfw_pkg::DEF_NUM_THREADS,
  parameter int COUNT_BITS  = rmfw_pkg::DEF_COUNT_BITS
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      req_valid,
  output logic                     req_ready,
  input  wire rmfw_pkg::req_beat_t req,
  output logic                     rsp_valid,
  input  wire                      rsp_ready,
  output rmfw_pkg::rsp_beat_t      rsp
);

  localparam int IDX_W  = $clog2(NUM_THREADS);
  localparam int FILL_W = $clog2(NUM_THREADS + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                  state, state_next;
  logic                    req_mode;
  logic [rmfw_pkg::TID_W-1:0] req_tid;

  logic                    held, held_next;
  logic [IDX_W-1:0]        owner, owner_next;
  logic [COUNT_BITS-1:0]   depth, depth_next;
  logic [IDX_W-1:0]        head, head_next;
  logic [IDX_W-1:0]        tail, tail_next;
  logic [FILL_W-1:0]       fill, fill_next;
  logic [NUM_THREADS-1:0]  waiting_map, waiting_map_next;

  logic [IDX_W-1:0]        queue_mem [NUM_THREADS];
  logic [IDX_W-1:0]        queue_rd;

  logic                    tid_ok;
  logic [IDX_W-1:0]        tid_idx;
  logic                    commit;
  logic                    mem_we;
  logic [rmfw_pkg::STATUS_W-1:0] status;
  logic                    woken_valid;
  logic [IDX_W-1:0]        woken;
  rmfw_pkg::rsp_beat_t     rsp_next;

  assign req_ready = (state == S_IDLE);
  assign commit    = (state == S_EXEC) && (!rsp_valid || rsp_ready);
  assign tid_ok    = (32'(req_tid) < 32'(NUM_THREADS));
  assign tid_idx   = IDX_W'(req_tid);

  always_comb begin
    held_next        = held;
    owner_next       = owner;
    depth_next       = depth;
    head_next        = head;
    tail_next        = tail;
    fill_next        = fill;
    waiting_map_next = waiting_map;
    mem_we           = 1'b0;
    woken_valid      = 1'b0;
    woken            = '0;
    status           = rmfw_pkg::ST_NOT_HOLDER;
    if (!tid_ok) begin
      status = rmfw_pkg::ST_NOT_HOLDER;
    end else if (req_mode == rmfw_pkg::MODE_ACQUIRE) begin
      if (!held) begin
        held_next  = 1'b1;
        owner_next = tid_idx;
        depth_next = COUNT_BITS'(1);
        status     = rmfw_pkg::ST_GRANT;
      end else if (owner == tid_idx) begin
        if (depth == '1) begin
          status = rmfw_pkg::ST_OVERFLOW;
        end else begin
          depth_next = depth + COUNT_BITS'(1);
          status     = rmfw_pkg::ST_RECURSED;
        end
      end else if (waiting_map[tid_idx] || fill >= FILL_W'(NUM_THREADS)) begin
        status = rmfw_pkg::ST_DUP_WAIT;
      end else begin
        mem_we                    = 1'b1;
        tail_next                 = (tail == IDX_W'(NUM_THREADS - 1)) ? '0 : tail + IDX_W'(1);
        fill_next                 = fill + FILL_W'(1);
        waiting_map_next[tid_idx] = 1'b1;
        status                    = rmfw_pkg::ST_BLOCKED;
      end
    end else begin
      if (!held || owner != tid_idx) begin
        status = rmfw_pkg::ST_NOT_HOLDER;
      end else if (depth > COUNT_BITS'(1)) begin
        depth_next = depth - COUNT_BITS'(1);
        status     = rmfw_pkg::ST_LOWERED;
      end else if (fill != '0) begin
        head_next                  = (head == IDX_W'(NUM_THREADS - 1)) ? '0 : head + IDX_W'(1);
        fill_next                  = fill - FILL_W'(1);
        waiting_map_next[queue_rd] = 1'b0;
        owner_next                 = queue_rd;
        depth_next                 = COUNT_BITS'(1);
        woken_valid                = 1'b1;
        woken                      = queue_rd;
        status                     = rmfw_pkg::ST_HANDOFF;
      end else begin
        held_next  = 1'b0;
        owner_next = '0;
        depth_next = '0;
        status     = rmfw_pkg::ST_FREED;
      end
    end
  end

  always_comb begin
    rsp_next.status        = status;
    rsp_next.woken_valid   = woken_valid;
    rsp_next.woken_thread  = rmfw_pkg::TID_W'(woken);
    rsp_next.lock_held     = held_next;
    rsp_next.holder_thread = held_next ? rmfw_pkg::TID_W'(owner_next) : '0;
    rsp_next.hold_count    = held_next ? rmfw_pkg::HOLD_W'(depth_next) : '0;
    rsp_next.waiting_count = rmfw_pkg::WAIT_W'(fill_next);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (commit && mem_we) queue_mem[tail] <= tid_idx;
    queue_rd <= queue_mem[head];
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_mode <= req.mode;
      req_tid  <= req.thread_id;
    end
    if (commit) rsp <= rsp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      held        <= 1'b0;
      owner       <= '0;
      depth       <= '0;
      head        <= '0;
      tail        <= '0;
      fill        <= '0;
      waiting_map <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        held        <= held_next;
        owner       <= owner_next;
        depth       <= depth_next;
        head        <= head_next;
        tail        <= tail_next;
        fill        <= fill_next;
        waiting_map <= waiting_map_next;
        rsp_valid   <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_map_matches_fill: assert property (@(posedge clk) disable iff (rst)
    $countones(waiting_map) == 32'(fill))
    else $error("waiting map population differs from queue fill");

  a_free_means_empty: assert property (@(posedge clk) disable iff (rst)
    !held |-> (depth == '0 && fill == '0 && owner == '0))
    else $error("free lock with depth, owner or waiters");

  a_held_depth: assert property (@(posedge clk) disable iff (rst)
    held |-> depth != '0)
    else $error("held lock with zero depth");

  a_wake_is_holder: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.woken_valid) |->
      (rsp.lock_held && rsp.holder_thread == rsp.woken_thread &&
       rsp.status == rmfw_pkg::ST_HANDOFF))
    else $error("woken thread not reported as holder");

endmodule
`default_nettype wire
